// File: design/olir_pkg.sv
// Shared types and codes for the ordered list insert/remove block.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package olir_pkg;

    localparam int unsigned OP_W     = 3;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned VAL_W    = 32;
    localparam int unsigned OUT_CNT_W = 5;
    localparam int unsigned STAT_W   = 2;

    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
    localparam logic [OP_W-1:0] OP_REM_FRONT = 3'd3;
    localparam logic [OP_W-1:0] OP_REM_BACK  = 3'd4;
    localparam logic [OP_W-1:0] OP_REM_AT    = 3'd5;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic signed [VAL_W-1:0] removed_value;
        logic [OUT_CNT_W-1:0]    element_count;
        logic [STAT_W-1:0]       status;
    } t_rsp;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_INS  = 2'd1,
        ACT_REM  = 2'd2
    } t_act;

    typedef enum logic [1:0] {
        SEL_FRONT = 2'd0,
        SEL_BACK  = 2'd1,
        SEL_POS   = 2'd2
    } t_sel;

    typedef struct packed {
        logic              load;
        t_act              act;
        t_sel              sel;
        logic [STAT_W-1:0] status;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic ins_pos_ok;
        logic rem_pos_ok;
    } t_stat;

endpackage

`default_nettype wire

// File: design/olir_stream_if.sv
// Valid/ready stream channel carrying one request or response payload.
// Depends on nothing; the payload type is given at instantiation.
`default_nettype none

interface olir_stream_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: design/olir_ctrl.sv
// Controller for the ordered list: handshake state machine and operation decode.
// Depends on olir_pkg.
`default_nettype none

module olir_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_req_valid,
    input  wire logic [olir_pkg::OP_W-1:0]   i_operation,
    input  wire logic                        i_rsp_ready,
    input  wire olir_pkg::t_stat             i_stat,
    output logic                             o_req_ready,
    output logic                             o_rsp_valid,
    output olir_pkg::t_cmd                   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SEND = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_rsp_valid = (r_state == S_SEND);
    assign o_req_ready = (r_state == S_IDLE) || i_rsp_ready;
    assign w_accept    = i_req_valid && o_req_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_SEND;
            end
            S_SEND: begin
                if (w_accept) n_state = S_SEND;
                else if (i_rsp_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd.load   = w_accept;
        o_cmd.act    = olir_pkg::ACT_NONE;
        o_cmd.sel    = olir_pkg::SEL_FRONT;
        o_cmd.status = olir_pkg::ST_DONE;
        case (i_operation)
            olir_pkg::OP_INS_FRONT, olir_pkg::OP_INS_BACK, olir_pkg::OP_INS_AT: begin
                if (i_operation == olir_pkg::OP_INS_FRONT) o_cmd.sel = olir_pkg::SEL_FRONT;
                else if (i_operation == olir_pkg::OP_INS_BACK) o_cmd.sel = olir_pkg::SEL_BACK;
                else o_cmd.sel = olir_pkg::SEL_POS;
                if (i_stat.full) begin
                    o_cmd.status = olir_pkg::ST_FULL;
                end else if (i_operation == olir_pkg::OP_INS_AT && !i_stat.ins_pos_ok) begin
                    o_cmd.status = olir_pkg::ST_RANGE;
                end else begin
                    o_cmd.act = olir_pkg::ACT_INS;
                end
            end
            olir_pkg::OP_REM_FRONT, olir_pkg::OP_REM_BACK, olir_pkg::OP_REM_AT: begin
                if (i_operation == olir_pkg::OP_REM_FRONT) o_cmd.sel = olir_pkg::SEL_FRONT;
                else if (i_operation == olir_pkg::OP_REM_BACK) o_cmd.sel = olir_pkg::SEL_BACK;
                else o_cmd.sel = olir_pkg::SEL_POS;
                if (i_stat.empty) begin
                    o_cmd.status = olir_pkg::ST_EMPTY;
                end else if (i_operation == olir_pkg::OP_REM_AT && !i_stat.rem_pos_ok) begin
                    o_cmd.status = olir_pkg::ST_RANGE;
                end else begin
                    o_cmd.act = olir_pkg::ACT_REM;
                end
            end
            default: begin
                o_cmd.act = olir_pkg::ACT_NONE;
            end
        endcase
        if (!w_accept) o_cmd.act = olir_pkg::ACT_NONE;
    end

endmodule

`default_nettype wire

// File: design/olir_datapath.sv
// Datapath for the ordered list: row of element cells, count and response register.
// Depends on olir_pkg; driven by commands from olir_ctrl.
`default_nettype none

module olir_datapath #(
    parameter int CAPACITY = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire olir_pkg::t_cmd                    i_cmd,
    input  wire logic [olir_pkg::POS_W-1:0]        i_position,
    input  wire logic signed [olir_pkg::VAL_W-1:0] i_value,
    output olir_pkg::t_stat                        o_stat,
    output olir_pkg::t_rsp                         o_rsp
);

    localparam int IW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int PCW = (CW > olir_pkg::POS_W) ? CW : olir_pkg::POS_W;
    localparam int XW  = (CW > olir_pkg::OUT_CNT_W) ? CW : olir_pkg::OUT_CNT_W;

    logic signed [olir_pkg::VAL_W-1:0] r_cell [CAPACITY];
    logic signed [olir_pkg::VAL_W-1:0] n_cell [CAPACITY];
    logic [CW-1:0]                     r_count;
    logic [CW-1:0]                     n_count;
    olir_pkg::t_rsp                    r_rsp;
    olir_pkg::t_rsp                    n_rsp;
    logic [PCW-1:0]                    w_pos_ext;
    logic [PCW-1:0]                    w_cnt_ext;
    logic [CW-1:0]                     w_cnt_dec;
    logic [PCW-1:0]                    w_pos_idx;
    logic [IW-1:0]                     w_idx;
    logic [XW-1:0]                     w_cnt_out;

    assign w_pos_ext = PCW'(i_position);
    assign w_cnt_ext = PCW'(r_count);
    assign w_cnt_dec = r_count - CW'(1);
    assign w_pos_idx = w_pos_ext;

    assign o_stat.full       = (r_count == CW'(CAPACITY));
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.ins_pos_ok = (w_pos_ext <= w_cnt_ext);
    assign o_stat.rem_pos_ok = (w_pos_ext < w_cnt_ext);

    always_comb begin
        case (i_cmd.sel)
            olir_pkg::SEL_FRONT: w_idx = '0;
            olir_pkg::SEL_BACK: begin
                if (i_cmd.act == olir_pkg::ACT_REM) w_idx = w_cnt_dec[IW-1:0];
                else w_idx = r_count[IW-1:0];
            end
            olir_pkg::SEL_POS: w_idx = w_pos_idx[IW-1:0];
            default: w_idx = '0;
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam logic [IW-1:0] G_IDX = IW'(g);
        always_comb begin
            n_cell[g] = r_cell[g];
            if (i_cmd.act == olir_pkg::ACT_INS) begin
                if (w_idx == G_IDX) begin
                    n_cell[g] = i_value;
                end else if (w_idx < G_IDX) begin
                    if (g > 0) n_cell[g] = r_cell[(g > 0) ? g - 1 : 0];
                end
            end else if (i_cmd.act == olir_pkg::ACT_REM) begin
                if (w_idx <= G_IDX) begin
                    if (g < CAPACITY - 1) n_cell[g] = r_cell[(g < CAPACITY - 1) ? g + 1 : g];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.act != olir_pkg::ACT_NONE) r_cell[g] <= n_cell[g];
        end
    end

    always_comb begin
        case (i_cmd.act)
            olir_pkg::ACT_INS: n_count = r_count + CW'(1);
            olir_pkg::ACT_REM: n_count = w_cnt_dec;
            default:           n_count = r_count;
        endcase
    end

    assign w_cnt_out = XW'(n_count);

    always_comb begin
        n_rsp.removed_value = '0;
        if (i_cmd.act == olir_pkg::ACT_REM) n_rsp.removed_value = r_cell[w_idx];
        n_rsp.element_count = w_cnt_out[olir_pkg::OUT_CNT_W-1:0];
        n_rsp.status        = i_cmd.status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_rsp <= n_rsp;
    end

    assign o_rsp = r_rsp;

endmodule

`default_nettype wire

// File: design/ordered_list_insert_remove_core.sv
// Ordered list of signed 32-bit values with insert and remove at front, back or position.
// Requests arrive on i_req (operation, position, value); one response per request
// leaves on o_rsp (removed_value, element_count, status). Both are valid/ready
// channels; a transfer happens at a clock edge with valid and ready both high.
// Each accepted request is executed in the cycle it is accepted: all elements at or
// past the target shift one place in parallel through a row of register cells, and
// the response is captured in an output register and shown the next cycle.
// Throughput is one request per cycle while the receiver takes responses; a new request
// is taken in the same cycle the pending response leaves. When the receiver stalls, the
// held response stays stable and i_req.ready drops, so at most one response waits. Full,
// empty and out-of-range requests are answered with their status and leave the list
// unchanged.
// Synchronous active-low reset empties the list and drops any pending response;
// element contents are not cleared and are never read before being written.
// Depends on olir_pkg, olir_stream_if, olir_ctrl and olir_datapath.
`default_nettype none

module ordered_list_insert_remove_core #(
    parameter int CAPACITY = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    olir_stream_if.sink        i_req,
    olir_stream_if.source      o_rsp
);

    olir_pkg::t_cmd  w_cmd;
    olir_pkg::t_stat w_stat;
    olir_pkg::t_req  w_req;

    assign w_req = i_req.payload;

    olir_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_operation (w_req.operation),
        .i_rsp_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_cmd       (w_cmd)
    );

    olir_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_position (w_req.position),
        .i_value    (w_req.value),
        .o_stat     (w_stat),
        .o_rsp      (o_rsp.payload)
    );

endmodule

`default_nettype wire
